// ===== src/assert_macros.svh =====
// Assertion macros used by the ranker RTL.
// No dependencies; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked while out of reset.
`define ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked while out of reset.
`define ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== src/tkr_pkg.sv =====
// Types and constants for the top-k score table ranker.
// No dependencies.
`default_nettype none

package tkr_pkg;

    localparam int ENTRIES_DEF = 8;
    localparam int SCORE_W     = 31;
    localparam int TAG_W       = 16;
    localparam int POS_W       = 3;
    localparam int RANK_W      = 4;

    typedef struct packed {
        logic [SCORE_W-1:0] score;
        logic [TAG_W-1:0]   tag;
    } entry_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ADM_RD,
        ST_ADM,
        ST_SORT,
        ST_WB,
        ST_EMIT,
        ST_DRAIN
    } state_t;

endpackage

`default_nettype wire

// ===== src/top_k_score_table_ranker.sv =====
// Top-k score table ranker: sorted table of scores and tags in one RAM.
// Depends on tkr_pkg and assert_macros.svh.
`default_nettype none

// Usage
//   Command channel: an offer (offered_score, offered_tag) is taken at a
//   rising edge with start high and busy low. busy stays high until the
//   table has been sorted and all but the final result beat are out.
//   Result channel: ENTRIES beats, one per cycle, each marked by out_valid
//   for exactly one cycle, slot 0 first; last_entry flags the final beat.
//   The receiver cannot stall; beats are simply presented and gone.
// Timing
//   All table entries live in one single-port-write, registered-read RAM.
//   An offer goes through the admission check, then one sort pass for each
//   a in 0..ENTRIES-2: the RAM read port carries one compare per cycle and
//   each pass ends with a write-back of the held entry. Emission reads
//   ENTRIES slots back to back. A new offer is taken only once the
//   previous one has been sorted and all but its final beat are out.
// Reset
//   rst_n clears per-entry valid bits; a slot never written reads as score
//   and tag zero, so no clearing pass is needed.
module top_k_score_table_ranker
#(
    parameter int ENTRIES = tkr_pkg::ENTRIES_DEF
)
(
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         start,
    output logic                              busy,
    input  wire logic [tkr_pkg::SCORE_W-1:0]  offered_score,
    input  wire logic [tkr_pkg::TAG_W-1:0]    offered_tag,
    output logic                              out_valid,
    output logic [tkr_pkg::POS_W-1:0]         position,
    output logic [tkr_pkg::RANK_W-1:0]        rank,
    output logic [tkr_pkg::SCORE_W-1:0]       entry_score,
    output logic [tkr_pkg::TAG_W-1:0]         entry_tag,
    output logic                              admitted,
    output logic                              last_entry
);
    import tkr_pkg::*;

`include "assert_macros.svh"

    localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CNT_W = $clog2(ENTRIES + 1);
    localparam logic [IDX_W-1:0] LAST_IDX  = IDX_W'(ENTRIES - 1);
    localparam logic [IDX_W-1:0] PENUL_IDX = IDX_W'(ENTRIES - 2);
    localparam logic [CNT_W-1:0] LAST_CNT  = CNT_W'(ENTRIES - 1);
    localparam logic [CNT_W-1:0] END_CNT   = CNT_W'(ENTRIES);

    // Table RAM and its valid bits
    entry_t                 mem [ENTRIES];
    logic [ENTRIES-1:0]     vld_reg;
    entry_t                 q_reg;
    logic                   rd_vld_reg;

    logic                   mem_re;
    logic [IDX_W-1:0]       mem_ra;
    logic                   mem_we;
    logic [IDX_W-1:0]       mem_wa;
    entry_t                 mem_wd;

    // Read tracking: which slot the RAM output belongs to, and why it was read
    logic [IDX_W-1:0]       rd_idx_reg;
    logic                   rd_is_a_reg, rd_is_a_next;
    logic                   rd_sort_reg, rd_sort_next;
    logic                   rd_emit_reg, rd_emit_next;

    // Sequencer
    state_t                 state_reg, state_next;
    logic [IDX_W-1:0]       a_reg, a_next;
    logic [CNT_W-1:0]       ptr_reg, ptr_next;
    entry_t                 a_ent_reg, a_ent_next;
    entry_t                 off_reg;
    logic                   adm_reg, adm_next;

    // Result beat registers
    logic                   ov_reg, ov_next;
    logic [POS_W-1:0]       pos_reg, pos_next;
    logic [CNT_W-1:0]       rank_reg, rank_next;
    entry_t                 ent_reg, ent_next;
    logic                   oadm_reg, oadm_next;
    logic                   last_reg, last_next;
    logic [SCORE_W-1:0]     prev_score_reg, prev_score_next;

    entry_t                 rd_ent;
    logic                   accept;

    assign accept = start && (state_reg == ST_IDLE);
    assign busy   = (state_reg != ST_IDLE);
    assign rd_ent = rd_vld_reg ? q_reg : '0;

    // ---------------- RAM ----------------
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_wa] <= mem_wd;
        end
        if (mem_re)
        begin
            q_reg <= mem[mem_ra];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg    <= '0;
            rd_vld_reg <= 1'b0;
        end
        else
        begin
            if (mem_we)
            begin
                vld_reg[mem_wa] <= 1'b1;
            end
            if (mem_re)
            begin
                rd_vld_reg <= vld_reg[mem_ra];
            end
        end
    end

    // ---------------- next state ----------------
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    state_next = ST_ADM_RD;
                end
            end
            ST_ADM_RD: state_next = ST_ADM;
            ST_ADM:    state_next = ST_SORT;
            ST_SORT:
            begin
                if (rd_sort_reg && (rd_idx_reg == LAST_IDX))
                begin
                    state_next = ST_WB;
                end
            end
            ST_WB:
            begin
                if (a_reg == PENUL_IDX)
                begin
                    state_next = ST_EMIT;
                end
                else
                begin
                    state_next = ST_SORT;
                end
            end
            ST_EMIT:
            begin
                if (ptr_reg == LAST_CNT)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:  state_next = ST_IDLE;
            default:   state_next = ST_IDLE;
        endcase
    end

    // ---------------- sequencer outputs ----------------
    // Reads and writes never hit the same slot in one cycle: a compare writes
    // slot b while slot b+1 is read, write-back of slot a goes with a read of
    // a+1, and the admission write to the last slot goes with a read of 0.
    always_comb
    begin
        mem_re       = 1'b0;
        mem_ra       = '0;
        mem_we       = 1'b0;
        mem_wa       = '0;
        mem_wd       = a_ent_reg;
        rd_is_a_next = 1'b0;
        rd_sort_next = 1'b0;
        rd_emit_next = 1'b0;
        a_next       = a_reg;
        ptr_next     = ptr_reg;
        a_ent_next   = a_ent_reg;
        adm_next     = adm_reg;
        case (state_reg)
            ST_IDLE:
            begin
            end
            ST_ADM_RD:
            begin
                mem_re = 1'b1;
                mem_ra = LAST_IDX;
            end
            ST_ADM:
            begin
                adm_next = (off_reg.score > rd_ent.score);
                if (off_reg.score > rd_ent.score)
                begin
                    mem_we = 1'b1;
                    mem_wa = LAST_IDX;
                    mem_wd = off_reg;
                end
                mem_re       = 1'b1;
                mem_ra       = '0;
                rd_is_a_next = 1'b1;
                a_next       = '0;
                ptr_next     = CNT_W'(1);
            end
            ST_SORT:
            begin
                if (ptr_reg < END_CNT)
                begin
                    mem_re       = 1'b1;
                    mem_ra       = ptr_reg[IDX_W-1:0];
                    rd_sort_next = 1'b1;
                    ptr_next     = ptr_reg + CNT_W'(1);
                end
                if (rd_is_a_reg)
                begin
                    a_ent_next = rd_ent;
                end
                else if (rd_sort_reg && (a_ent_reg.score <= rd_ent.score))
                begin
                    // swap: held slot a takes b, slot b takes old a
                    mem_we     = 1'b1;
                    mem_wa     = rd_idx_reg;
                    mem_wd     = a_ent_reg;
                    a_ent_next = rd_ent;
                end
            end
            ST_WB:
            begin
                mem_we = 1'b1;
                mem_wa = a_reg;
                mem_wd = a_ent_reg;
                if (a_reg == PENUL_IDX)
                begin
                    ptr_next = '0;
                end
                else
                begin
                    mem_re       = 1'b1;
                    mem_ra       = a_reg + IDX_W'(1);
                    rd_is_a_next = 1'b1;
                    a_next       = a_reg + IDX_W'(1);
                    ptr_next     = CNT_W'(a_reg) + CNT_W'(2);
                end
            end
            ST_EMIT:
            begin
                mem_re       = 1'b1;
                mem_ra       = ptr_reg[IDX_W-1:0];
                rd_emit_next = 1'b1;
                ptr_next     = ptr_reg + CNT_W'(1);
            end
            ST_DRAIN:
            begin
            end
            default:
            begin
            end
        endcase
    end

    // ---------------- result beat ----------------
    // Table is sorted descending, so rank changes only where the score does.
    always_comb
    begin
        ov_next         = rd_emit_reg;
        pos_next        = pos_reg;
        rank_next       = rank_reg;
        ent_next        = ent_reg;
        oadm_next       = oadm_reg;
        last_next       = 1'b0;
        prev_score_next = prev_score_reg;
        if (rd_emit_reg)
        begin
            pos_next        = POS_W'(rd_idx_reg);
            ent_next        = rd_ent;
            oadm_next       = adm_reg;
            last_next       = (rd_idx_reg == LAST_IDX);
            prev_score_next = rd_ent.score;
            if ((rd_idx_reg == '0) || (rd_ent.score != prev_score_reg))
            begin
                rank_next = CNT_W'(rd_idx_reg) + CNT_W'(1);
            end
        end
    end

    // ---------------- registers ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            rd_is_a_reg <= 1'b0;
            rd_sort_reg <= 1'b0;
            rd_emit_reg <= 1'b0;
            ov_reg      <= 1'b0;
            last_reg    <= 1'b0;
            a_reg       <= '0;
            ptr_reg     <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            rd_is_a_reg <= rd_is_a_next;
            rd_sort_reg <= rd_sort_next;
            rd_emit_reg <= rd_emit_next;
            ov_reg      <= ov_next;
            last_reg    <= last_next;
            a_reg       <= a_next;
            ptr_reg     <= ptr_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_re)
        begin
            rd_idx_reg <= mem_ra;
        end
        if (accept)
        begin
            off_reg.score <= offered_score;
            off_reg.tag   <= offered_tag;
        end
        a_ent_reg      <= a_ent_next;
        adm_reg        <= adm_next;
        pos_reg        <= pos_next;
        rank_reg       <= rank_next;
        ent_reg        <= ent_next;
        oadm_reg       <= oadm_next;
        prev_score_reg <= prev_score_next;
    end

    assign out_valid   = ov_reg;
    assign position    = pos_reg;
    assign rank        = RANK_W'(rank_reg);
    assign entry_score = ent_reg.score;
    assign entry_tag   = ent_reg.tag;
    assign admitted    = oadm_reg;
    assign last_entry  = last_reg;

    // ---------------- assertions ----------------
    `ASSERT_IMP(a_no_rw_clash, clk, rst_n, mem_we && mem_re, mem_wa != mem_ra,
                "RAM read and write hit the same slot")
    `ASSERT_IMP(a_read_kind, clk, rst_n, 1'b1,
                $onehot0({rd_is_a_reg, rd_sort_reg, rd_emit_reg}),
                "RAM read tagged with more than one use")
    `ASSERT_IMP(a_last_beat_idle, clk, rst_n, out_valid && last_entry, !busy,
                "final beat while still busy")
    `ASSERT_IMP(a_mid_beat_busy, clk, rst_n, out_valid && !last_entry, busy,
                "result beat out while idle")
    `ASSERT_NXT(a_wb_after_last, clk, rst_n,
                (state_reg == ST_SORT) && rd_sort_reg && (rd_idx_reg == LAST_IDX),
                state_reg == ST_WB, "sort pass did not end in write-back")

endmodule

`default_nettype wire
